[design/tbled_pkg.sv]
// Shared types and constants for the two-button LED mode controller.
// No dependencies; imported by two_button_led_mode_controller.
package tbled_pkg;

  // debounced button class
  typedef enum logic [1:0] {
    HC_ONE  = 2'd0,
    HC_TWO  = 2'd1,
    HC_BOTH = 2'd2,
    HC_NONE = 2'd3
  } held_t;

  // led mode
  typedef enum logic [1:0] {
    MODE_BLINK = 2'd0,
    MODE_ON    = 2'd1,
    MODE_OFF   = 2'd2
  } mode_t;

  // action emitted on release
  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_SHORT_ONE = 3'd1,
    ACT_LONG_ONE  = 3'd2,
    ACT_SHORT_TWO = 3'd3,
    ACT_LONG_TWO  = 3'd4,
    ACT_BOTH      = 3'd5
  } action_t;

  // configuration register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_DELAY_STEP = 3'd0,
    REG_MIN_DELAY  = 3'd1,
    REG_MAX_DELAY  = 3'd2,
    REG_LONG_PRESS = 3'd3,
    REG_INIT_DELAY = 3'd4
  } reg_idx_t;

  localparam int unsigned MS_W    = 16;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [MS_W-1:0] AGE_MAX            = 16'hFFFF;
  localparam logic [MS_W-1:0] RST_DELAY_STEP     = 16'd100;
  localparam logic [MS_W-1:0] RST_MIN_DELAY      = 16'd100;
  localparam logic [MS_W-1:0] RST_MAX_DELAY      = 16'd1000;
  localparam logic [MS_W-1:0] RST_LONG_PRESS     = 16'd1000;
  localparam logic [MS_W-1:0] RST_INIT_DELAY     = 16'd500;

endpackage

[design/two_button_led_mode_controller.sv]
// Two-button LED mode controller: debounce, press classification, mode and blink logic.
// Depends on tbled_pkg for types and reset constants.
//
// Each request is one loop step (two sample pairs plus elapsed milliseconds) and
// yields one result. Requests are taken one per clock: a request lands in an input
// register, the whole step is evaluated combinationally against the state registers,
// and the result is written to an output register once that register is empty or
// being read, which also commits the new state.
// The state feedback through the single evaluation stage sets the one-request-per-cycle
// rate. A full output register backs up into the input register and then into in_ready.
// Configuration registers sit on an APB-style port (byte address 4*index, 32-bit
// data, low 16 bits used); writing initial_delay_ms also loads the blink delay.
module two_button_led_mode_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_first_sample_a,
  input  logic                        in_first_sample_b,
  input  logic                        in_second_sample_a,
  input  logic                        in_second_sample_b,
  input  logic [9:0]                  in_elapsed_ms,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_led_one,
  output logic                        out_led_two,
  output logic [2:0]                  out_press_action,
  output logic [1:0]                  out_led_mode,
  output logic [15:0]                 out_current_delay_ms,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tbled_pkg::ADDR_W-1:0] paddr,
  input  logic [tbled_pkg::DATA_W-1:0] pwdata,
  output logic [tbled_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tbled_pkg::*;

  // configuration registers
  logic [MS_W-1:0] delay_step_r, min_delay_r, max_delay_r, long_press_r, init_delay_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  // input register
  logic                 s1_valid_r;
  logic                 fa_r, fb_r, sa_r, sb_r;
  logic [ELAPSED_W-1:0] el_r;
  logic                 s1_adv;

  // step state
  logic [1:0]      stable_r, stable_nxt;
  held_t           held_r, held_nxt;
  logic [MS_W-1:0] press_age_r, press_age_nxt;
  mode_t           mode_r, mode_nxt;
  logic            active_r, active_nxt;
  logic [MS_W-1:0] delay_r, delay_nxt;
  logic [MS_W-1:0] blink_age_r, blink_age_nxt;

  // step intermediates
  logic [MS_W:0]   press_sum, blink_sum, inc_sum;
  logic [MS_W-1:0] dec_diff;
  logic            b1, b2, lng;
  action_t         act;
  logic            led1, led2;

  // output register
  logic            out_valid_r;
  logic            led1_r, led2_r;
  action_t         act_r;
  mode_t           mode_out_r;
  logic [MS_W-1:0] delay_out_r;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // apb decode
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // register read
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_DELAY_STEP: prdata[MS_W-1:0] = delay_step_r;
      REG_MIN_DELAY:  prdata[MS_W-1:0] = min_delay_r;
      REG_MAX_DELAY:  prdata[MS_W-1:0] = max_delay_r;
      REG_LONG_PRESS: prdata[MS_W-1:0] = long_press_r;
      REG_INIT_DELAY: prdata[MS_W-1:0] = init_delay_r;
      default:        prdata = '0;
    endcase
  end

  // configuration write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_step_r <= RST_DELAY_STEP;
      min_delay_r  <= RST_MIN_DELAY;
      max_delay_r  <= RST_MAX_DELAY;
      long_press_r <= RST_LONG_PRESS;
      init_delay_r <= RST_INIT_DELAY;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELAY_STEP: delay_step_r <= pwdata[MS_W-1:0];
        REG_MIN_DELAY:  min_delay_r  <= pwdata[MS_W-1:0];
        REG_MAX_DELAY:  max_delay_r  <= pwdata[MS_W-1:0];
        REG_LONG_PRESS: long_press_r <= pwdata[MS_W-1:0];
        REG_INIT_DELAY: init_delay_r <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fa_r <= in_first_sample_a;
      fb_r <= in_first_sample_b;
      sa_r <= in_second_sample_a;
      sb_r <= in_second_sample_b;
      el_r <= in_elapsed_ms;
    end
  end

  // one loop step
  always_comb begin
    press_sum = {1'b0, press_age_r} + {{(MS_W+1-ELAPSED_W){1'b0}}, el_r};
    blink_sum = {1'b0, blink_age_r} + {{(MS_W+1-ELAPSED_W){1'b0}}, el_r};
    press_age_nxt = press_sum[MS_W] ? AGE_MAX : press_sum[MS_W-1:0];
    blink_age_nxt = blink_sum[MS_W] ? AGE_MAX : blink_sum[MS_W-1:0];
    mode_nxt   = mode_r;
    active_nxt = active_r;
    delay_nxt  = delay_r;
    act        = ACT_NONE;

    // debounce
    stable_nxt = stable_r;
    if (fa_r == sa_r && fb_r == sb_r) begin
      stable_nxt = {fb_r, fa_r};
    end
    b1 = stable_nxt[0];
    b2 = stable_nxt[1];

    // classify, both stays latched until full release
    if (b1 && b2) begin
      held_nxt = HC_BOTH;
    end else if (held_r == HC_BOTH && (b1 || b2)) begin
      held_nxt = HC_BOTH;
    end else if (b1) begin
      held_nxt = HC_ONE;
    end else if (b2) begin
      held_nxt = HC_TWO;
    end else begin
      held_nxt = HC_NONE;
    end

    // press start clears the press age
    if (held_r == HC_NONE && held_nxt != HC_NONE) begin
      press_age_nxt = '0;
    end

    // action on release
    lng = press_age_nxt >= long_press_r;
    if (held_nxt == HC_NONE) begin
      case (held_r)
        HC_BOTH: act = ACT_BOTH;
        HC_ONE:  act = lng ? ACT_LONG_ONE : ACT_SHORT_ONE;
        HC_TWO:  act = lng ? ACT_LONG_TWO : ACT_SHORT_TWO;
        default: act = ACT_NONE;
      endcase
    end

    // apply the action
    dec_diff = delay_r - delay_step_r;
    inc_sum  = {1'b0, delay_r} + {1'b0, delay_step_r};
    case (act)
      ACT_SHORT_ONE: begin
        if (mode_r == MODE_BLINK) begin
          if (delay_r < delay_step_r || dec_diff < min_delay_r) begin
            delay_nxt = min_delay_r;
          end else begin
            delay_nxt = dec_diff;
          end
        end else begin
          mode_nxt      = MODE_BLINK;
          active_nxt    = 1'b0;
          blink_age_nxt = '0;
        end
      end
      ACT_SHORT_TWO: begin
        if (mode_r == MODE_BLINK) begin
          if (inc_sum > {1'b0, max_delay_r}) begin
            delay_nxt = max_delay_r;
          end else begin
            delay_nxt = inc_sum[MS_W-1:0];
          end
        end else begin
          mode_nxt      = MODE_BLINK;
          active_nxt    = 1'b0;
          blink_age_nxt = '0;
        end
      end
      ACT_BOTH:     mode_nxt = MODE_ON;
      ACT_LONG_ONE: mode_nxt = MODE_OFF;
      ACT_LONG_TWO: mode_nxt = MODE_OFF;
      default: ;
    endcase

    // led levels before the toggle
    case (mode_nxt)
      MODE_BLINK: begin
        led1 = !active_nxt;
        led2 = active_nxt;
      end
      MODE_ON: begin
        led1 = 1'b1;
        led2 = 1'b1;
      end
      default: begin
        led1 = 1'b0;
        led2 = 1'b0;
      end
    endcase

    // blink toggle
    if (mode_nxt == MODE_BLINK && blink_age_nxt >= delay_nxt) begin
      active_nxt    = !active_nxt;
      blink_age_nxt = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r    <= 2'b00;
      held_r      <= HC_NONE;
      press_age_r <= '0;
      mode_r      <= MODE_BLINK;
      active_r    <= 1'b0;
      blink_age_r <= '0;
    end else if (s1_adv) begin
      stable_r    <= stable_nxt;
      held_r      <= held_nxt;
      press_age_r <= press_age_nxt;
      mode_r      <= mode_nxt;
      active_r    <= active_nxt;
      blink_age_r <= blink_age_nxt;
    end
  end

  // blink delay, also loaded by an initial delay write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= RST_INIT_DELAY;
    end else if (cfg_wr && cfg_idx == REG_INIT_DELAY) begin
      delay_r <= pwdata[MS_W-1:0];
    end else if (s1_adv) begin
      delay_r <= delay_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      led1_r      <= led1;
      led2_r      <= led2;
      act_r       <= act;
      mode_out_r  <= mode_nxt;
      delay_out_r <= delay_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_led_one          = led1_r;
  assign out_led_two          = led2_r;
  assign out_press_action     = act_r;
  assign out_led_mode         = mode_out_r;
  assign out_current_delay_ms = delay_out_r;

  // both-buttons release always ends in always-on mode
  a_both_gives_on: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && act == ACT_BOTH) |=> (mode_r == MODE_ON))
    else $error("both release did not select always-on mode");

  // an action only comes with a full release
  a_action_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && act != ACT_NONE) |=> (held_r == HC_NONE))
    else $error("action emitted without release");

  // blink mode always lights exactly one led
  a_blink_one_led: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_out_r == MODE_BLINK) |-> (led1_r != led2_r))
    else $error("blink mode result with both leds equal");

  // an empty output register never stalls the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule
